[rtl/tdc_spill_stream_unpacker_defines.svh]
// Assertion macros for the TDC spill stream unpacker.
`ifndef TDC_SPILL_STREAM_UNPACKER_DEFINES_SVH
`define TDC_SPILL_STREAM_UNPACKER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TDCSU_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("tdcsu check failed");
// next-cycle implication
`define TDCSU_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("tdcsu check failed");
`else
`define TDCSU_ASSERT_IMP(lbl, ck, rstn, ante, cons)
`define TDCSU_ASSERT_NXT(lbl, ck, rstn, ante, cons)
`endif

`endif

[rtl/tdcsu_pkg.sv]
// Types and constants shared by the TDC spill stream unpacker modules.
`default_nettype none
package tdcsu_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CTRL,
		ST_TDCH,
		ST_EVH,
		ST_DATA
	} parse_state_t;

	// section tags on results
	localparam logic [1:0] SECT_CTRL = 2'd0;
	localparam logic [1:0] SECT_TDCH = 2'd1;
	localparam logic [1:0] SECT_EVH  = 2'd2;
	localparam logic [1:0] SECT_DATA = 2'd3;

	// field codes, controller header
	localparam logic [3:0] FC_WORD_COUNT   = 4'd0;
	localparam logic [3:0] FC_SPILL_COUNT  = 4'd1;
	localparam logic [3:0] FC_YEAR         = 4'd2;
	localparam logic [3:0] FC_CTRL_TRIGS   = 4'd8;
	localparam logic [3:0] FC_TDC_STATUS   = 4'd9;
	localparam logic [3:0] FC_LINK_STATUS  = 4'd10;
	// TDC header
	localparam logic [3:0] FC_TDC_NUMBER   = 4'd1;
	localparam logic [3:0] FC_TDC_TRIGS    = 4'd2;
	localparam logic [3:0] FC_TDC_STAT     = 4'd3;
	// event header
	localparam logic [3:0] FC_EV_TDC       = 4'd1;
	localparam logic [3:0] FC_EV_STATUS    = 4'd2;
	localparam logic [3:0] FC_EV_TRIG_NUM  = 4'd3;
	localparam logic [3:0] FC_EV_TRIG_TYPE = 4'd4;
	localparam logic [3:0] FC_EV_CTRL_TS   = 4'd5;
	localparam logic [3:0] FC_EV_TDC_TS    = 4'd6;
	// event data
	localparam logic [3:0] FC_DATA         = 4'd0;

	localparam logic [15:0] EVH_WORDS = 16'd9;

	// config register indexes
	localparam logic REG_TDC_COUNT = 1'b0;
	localparam logic [4:0] TDC_COUNT_RST = 5'd16;

	// front-to-back queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = 2;
	localparam int QCNT_W = 3;

	// one queued word: one result, or two when packed (high byte, then low byte)
	typedef struct packed {
		logic        packed_pair;
		logic [1:0]  sect;
		logic [3:0]  code;
		logic [31:0] value;
		logic [3:0]  slot;
		logic [31:0] trig;
		logic        done;
	} res_entry_t;

	typedef struct packed {
		logic              empty;
		logic              full;
		logic [QCNT_W-1:0] count;
	} q_status_t;

endpackage
`default_nettype wire

[rtl/tdcsu_front.sv]
// Spill word parser: tracks section and counters, queues the results of each word.
`default_nettype none
module tdcsu_front import tdcsu_pkg::*; #(
	parameter int MAX_TDCS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_ready,
	input  wire logic [15:0] in_word,
	input  wire logic        in_start,
	input  wire logic [4:0]  tdc_count,
	output      logic        push,
	output      res_entry_t  entry
);

	localparam int CAP = (MAX_TDCS > 31) ? 31 : MAX_TDCS;
	localparam logic [4:0] CAP5 = 5'(CAP);

	parse_state_t state_q, st_e, st_n;
	logic [3:0]  wp_q, wp_e, wp_n;
	logic [15:0] hh_q, hh_e, hh_n;
	logic [4:0]  pos_q, pos_e, pos_n;
	logic [31:0] trig_q, trig_e, trig_n;
	logic [31:0] ttot_q, ttot_e, ttot_n;
	logic [15:0] etot_q, etot_e, etot_n;
	logic [15:0] eseen_q, eseen_e, eseen_n;

	logic        accept;
	logic [4:0]  use_n;
	logic        last_tdc, last_trig, ev_end, has_res;
	logic [15:0] eseen_inc;
	logic [31:0] joined;

	assign accept = in_valid & in_ready;

	// a spill start word restarts from a cleared state
	assign st_e    = in_start ? ST_CTRL : state_q;
	assign wp_e    = in_start ? 4'd0 : wp_q;
	assign hh_e    = in_start ? 16'd0 : hh_q;
	assign pos_e   = in_start ? 5'd0 : pos_q;
	assign trig_e  = in_start ? 32'd0 : trig_q;
	assign ttot_e  = in_start ? 32'd0 : ttot_q;
	assign etot_e  = in_start ? 16'd0 : etot_q;
	assign eseen_e = in_start ? 16'd0 : eseen_q;

	assign joined    = {hh_e, in_word};
	assign use_n     = (tdc_count > CAP5) ? CAP5 : tdc_count;
	assign last_tdc  = ({1'b0, pos_e} + 6'd1) >= {1'b0, use_n};
	assign last_trig = (({1'b0, trig_e} + 33'd1) >= {1'b0, ttot_e}) || (ttot_e == 32'd0);
	assign eseen_inc = eseen_e + 16'd1;

	// next state
	always_comb begin
		st_n    = st_e;
		wp_n    = wp_e;
		hh_n    = hh_e;
		pos_n   = pos_e;
		trig_n  = trig_e;
		ttot_n  = ttot_e;
		etot_n  = etot_e;
		eseen_n = eseen_e;
		ev_end  = 1'b0;
		case (st_e)
			ST_CTRL: begin
				if (wp_e == 4'd0 || wp_e == 4'd6) hh_n = in_word;
				if (wp_e == 4'd7) ttot_n = joined;
				if (wp_e >= 4'd9) begin
					wp_n  = 4'd0;
					pos_n = 5'd0;
					st_n  = (use_n == 5'd0) ? ST_IDLE : ST_TDCH;
				end else begin
					wp_n = wp_e + 4'd1;
				end
			end
			ST_TDCH: begin
				if (wp_e == 4'd0 || wp_e == 4'd3) hh_n = in_word;
				if (wp_e >= 4'd5) begin
					wp_n = 4'd0;
					if (last_tdc) begin
						pos_n = 5'd0;
						if (ttot_e == 32'd0) begin
							st_n = ST_IDLE;
						end else begin
							st_n   = ST_EVH;
							trig_n = 32'd0;
						end
					end else begin
						pos_n = pos_e + 5'd1;
					end
				end else begin
					wp_n = wp_e + 4'd1;
				end
			end
			ST_EVH: begin
				if (wp_e == 4'd0) etot_n = in_word;
				if (wp_e == 4'd3 || wp_e == 4'd7) hh_n = in_word;
				if (wp_e >= 4'd8) begin
					eseen_n = EVH_WORDS;
					if (EVH_WORDS < etot_e) begin
						st_n = ST_DATA;
						wp_n = 4'd0;
					end else begin
						ev_end = 1'b1;
					end
				end else begin
					wp_n = wp_e + 4'd1;
				end
			end
			ST_DATA: begin
				eseen_n = eseen_inc;
				if (eseen_inc >= etot_e) ev_end = 1'b1;
			end
			default: begin
			end
		endcase
		// event finished: next TDC, next trigger, or end of spill
		if (ev_end) begin
			wp_n = 4'd0;
			st_n = ST_EVH;
			if (last_tdc) begin
				pos_n = 5'd0;
				if (last_trig) st_n = ST_IDLE;
				else trig_n = trig_e + 32'd1;
			end else begin
				pos_n = pos_e + 5'd1;
			end
		end
	end

	// queued result
	always_comb begin
		has_res           = 1'b0;
		entry.packed_pair = 1'b0;
		entry.sect        = SECT_CTRL;
		entry.code        = FC_WORD_COUNT;
		entry.value       = {16'd0, in_word};
		entry.slot        = pos_e[3:0];
		entry.trig        = trig_e;
		entry.done        = 1'b0;
		case (st_e)
			ST_CTRL: begin
				entry.sect = SECT_CTRL;
				entry.done = (wp_e >= 4'd9) && (use_n == 5'd0);
				case (wp_e)
					4'd0, 4'd6: has_res = 1'b0;
					4'd1: begin
						has_res     = 1'b1;
						entry.code  = FC_WORD_COUNT;
						entry.value = joined;
					end
					4'd2: begin
						has_res    = 1'b1;
						entry.code = FC_SPILL_COUNT;
					end
					4'd3, 4'd4, 4'd5: begin
						// date/time byte pairs
						has_res           = 1'b1;
						entry.packed_pair = 1'b1;
						entry.code        = FC_YEAR + ((wp_e - 4'd3) << 1);
					end
					4'd7: begin
						has_res     = 1'b1;
						entry.code  = FC_CTRL_TRIGS;
						entry.value = joined;
					end
					4'd8: begin
						has_res    = 1'b1;
						entry.code = FC_TDC_STATUS;
					end
					default: begin
						has_res    = 1'b1;
						entry.code = FC_LINK_STATUS;
					end
				endcase
			end
			ST_TDCH: begin
				entry.sect = SECT_TDCH;
				entry.done = (wp_e >= 4'd5) && last_tdc && (ttot_e == 32'd0);
				case (wp_e)
					4'd0, 4'd3: has_res = 1'b0;
					4'd1: begin
						has_res     = 1'b1;
						entry.code  = FC_WORD_COUNT;
						entry.value = joined;
					end
					4'd2: begin
						has_res    = 1'b1;
						entry.code = FC_TDC_NUMBER;
					end
					4'd4: begin
						has_res     = 1'b1;
						entry.code  = FC_TDC_TRIGS;
						entry.value = joined;
					end
					default: begin
						has_res    = 1'b1;
						entry.code = FC_TDC_STAT;
					end
				endcase
			end
			ST_EVH: begin
				entry.sect = SECT_EVH;
				entry.done = ev_end && last_tdc && last_trig;
				case (wp_e)
					4'd0: begin
						has_res    = 1'b1;
						entry.code = FC_WORD_COUNT;
					end
					4'd1: begin
						has_res    = 1'b1;
						entry.code = FC_EV_TDC;
					end
					4'd2: begin
						has_res    = 1'b1;
						entry.code = FC_EV_STATUS;
					end
					4'd3, 4'd7: has_res = 1'b0;
					4'd4: begin
						has_res     = 1'b1;
						entry.code  = FC_EV_TRIG_NUM;
						entry.value = joined;
					end
					4'd5: begin
						has_res    = 1'b1;
						entry.code = FC_EV_TRIG_TYPE;
					end
					4'd6: begin
						has_res    = 1'b1;
						entry.code = FC_EV_CTRL_TS;
					end
					default: begin
						has_res     = 1'b1;
						entry.code  = FC_EV_TDC_TS;
						entry.value = joined;
					end
				endcase
			end
			ST_DATA: begin
				has_res    = 1'b1;
				entry.sect = SECT_DATA;
				entry.code = FC_DATA;
				entry.done = ev_end && last_tdc && last_trig;
			end
			default: has_res = 1'b0;
		endcase
	end

	assign push = accept & has_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			wp_q    <= 4'd0;
			hh_q    <= 16'd0;
			pos_q   <= 5'd0;
			trig_q  <= 32'd0;
			ttot_q  <= 32'd0;
			etot_q  <= 16'd0;
			eseen_q <= 16'd0;
		end else if (accept) begin
			state_q <= st_n;
			wp_q    <= wp_n;
			hh_q    <= hh_n;
			pos_q   <= pos_n;
			trig_q  <= trig_n;
			ttot_q  <= ttot_n;
			etot_q  <= etot_n;
			eseen_q <= eseen_n;
		end
	end

endmodule
`default_nettype wire

[rtl/tdcsu_queue.sv]
// Short FIFO of parsed words between the parser and the output stage.
`default_nettype none
module tdcsu_queue import tdcsu_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	input  wire res_entry_t push_data,
	input  wire logic       pop,
	output      res_entry_t head,
	output      q_status_t  status
);

	res_entry_t        mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QCNT_W-1:0] count_q;

	assign status.count = count_q;
	assign status.empty = (count_q == QCNT_W'(0));
	assign status.full  = (count_q == QCNT_W'(QDEPTH));
	assign head         = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + QPTR_W'(1);
			if (pop) rptr_q <= rptr_q + QPTR_W'(1);
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[rtl/tdcsu_back.sv]
// Output stage: splits packed byte pairs and holds the result register.
`default_nettype none
module tdcsu_back import tdcsu_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire res_entry_t  head,
	input  wire logic        q_empty,
	output      logic        pop,
	output      logic        split_busy,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic [1:0]  out_sect,
	output      logic [3:0]  out_code,
	output      logic [31:0] out_value,
	output      logic [3:0]  out_slot,
	output      logic [31:0] out_trig,
	output      logic        out_last,
	output      logic        out_done
);

	logic        valid_q, split_q, load;
	logic [1:0]  sect_q;
	logic [3:0]  code_q, slot_q;
	logic [31:0] value_q, trig_q;
	logic        last_q, done_q;

	assign load = (!valid_q || out_ready) && !q_empty;
	// a byte pair leaves the queue with its second result
	assign pop  = load && (!head.packed_pair || split_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			split_q <= 1'b0;
		end else begin
			if (load) valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
			if (load && head.packed_pair) split_q <= !split_q;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sect_q <= head.sect;
			slot_q <= head.slot;
			trig_q <= head.trig;
			if (head.packed_pair && !split_q) begin
				code_q  <= head.code;
				value_q <= {24'd0, head.value[15:8]};
				last_q  <= 1'b0;
				done_q  <= 1'b0;
			end else if (head.packed_pair) begin
				code_q  <= head.code + 4'd1;
				value_q <= {24'd0, head.value[7:0]};
				last_q  <= 1'b1;
				done_q  <= head.done;
			end else begin
				code_q  <= head.code;
				value_q <= head.value;
				last_q  <= 1'b1;
				done_q  <= head.done;
			end
		end
	end

	assign split_busy = split_q;
	assign out_valid  = valid_q;
	assign out_sect   = sect_q;
	assign out_code   = code_q;
	assign out_value  = value_q;
	assign out_slot   = slot_q;
	assign out_trig   = trig_q;
	assign out_last   = last_q;
	assign out_done   = done_q;

endmodule
`default_nettype wire

[rtl/tdc_spill_stream_unpacker.sv]
// Top level of the TDC spill stream unpacker: config register, parser, queue, output stage.
`default_nettype none
`include "tdc_spill_stream_unpacker_defines.svh"
// Unpacks a wire-chamber TDC spill arriving as 16-bit big-endian words on the
// input stream (tuser marks the first word of a spill and restarts parsing).
// Every completed field leaves as one output transfer tagged with section,
// field code, TDC slot and trigger index; tlast marks the last result of an
// input word and tuser[2] marks the result that completes the spill. Words
// outside a spill are dropped. The parser takes one word per clock; words
// that yield a result go into a four-entry queue, and the output register
// drains one result per clock while m_axis_tready is high. The three packed
// date/time words of the controller header give two results each and leave
// the queue only with the second; all other words sustain one per cycle.
// Input ready drops only when the queue is full. tdc_count (register 0,
// bits 4:0, reset 16) is clamped to MAX_TDCS and must be written over APB
// only while the block is idle; the block itself does not enforce this.
module tdc_spill_stream_unpacker import tdcsu_pkg::*; #(
	parameter int MAX_TDCS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB config
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready,
	// input words
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,   // [15:0] word
	input  wire logic        s_axis_tuser,   // [0] spill_start
	// results
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [71:0] m_axis_tdata,   // [3:0] field_code, [35:4] value,
	                                         // [39:36] tdc_slot, [71:40] trigger_index
	output      logic        m_axis_tlast,   // last_of_run
	output      logic [2:0]  m_axis_tuser    // [1:0] section, [2] spill_done
);

	logic [4:0]  tdc_count_q;
	logic        cfg_wr;
	logic        push, pop, split_busy;
	res_entry_t  push_data, head;
	q_status_t   q_stat;
	logic [1:0]  out_sect;
	logic [3:0]  out_code, out_slot;
	logic [31:0] out_value, out_trig;
	logic        out_last, out_done;

	// config register
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tdc_count_q <= TDC_COUNT_RST;
		end else if (cfg_wr && paddr[2] == REG_TDC_COUNT) begin
			tdc_count_q <= pwdata[4:0];
		end
	end

	assign prdata = (paddr[2] == REG_TDC_COUNT) ? {27'd0, tdc_count_q} : 32'd0;

	// parser takes a word whenever the queue has room
	assign s_axis_tready = !q_stat.full;

	tdcsu_front #(
		.MAX_TDCS(MAX_TDCS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_word  (s_axis_tdata),
		.in_start (s_axis_tuser),
		.tdc_count(tdc_count_q),
		.push     (push),
		.entry    (push_data)
	);

	tdcsu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head     (head),
		.status   (q_stat)
	);

	tdcsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (q_stat.empty),
		.pop       (pop),
		.split_busy(split_busy),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_sect  (out_sect),
		.out_code  (out_code),
		.out_value (out_value),
		.out_slot  (out_slot),
		.out_trig  (out_trig),
		.out_last  (out_last),
		.out_done  (out_done)
	);

	assign m_axis_tdata = {out_trig, out_slot, out_value, out_code};
	assign m_axis_tlast = out_last;
	assign m_axis_tuser = {out_done, out_sect};

	// queue never overfills
	`TDCSU_ASSERT_IMP(a_q_bound, clk, arst_n, 1'b1, q_stat.count <= QCNT_W'(QDEPTH))
	// spill end is always on the final result of its word
	`TDCSU_ASSERT_IMP(a_done_last, clk, arst_n, m_axis_tvalid && m_axis_tuser[2], m_axis_tlast)
	// mid-pair: first byte of a controller date/time word is on the output
	`TDCSU_ASSERT_IMP(a_split_ctrl, clk, arst_n, split_busy,
		m_axis_tvalid && !m_axis_tlast && m_axis_tuser[1:0] == SECT_CTRL)
	// a second byte is queued behind a pending first byte
	`TDCSU_ASSERT_IMP(a_split_queued, clk, arst_n, split_busy,
		!q_stat.empty && head.packed_pair)

endmodule
`default_nettype wire
